// File: sv/vector_matrix_product_assert.svh
// Assertion macros for the vector-matrix product block.
// Depends on: signals clk and rst_n in the module that includes this file.
`ifndef VECTOR_MATRIX_PRODUCT_ASSERT_SVH
`define VECTOR_MATRIX_PRODUCT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define VMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vmp_pkg.sv
// Shared types, constants and helpers for the vector-matrix product block.
// No dependencies.
package vmp_pkg;

    localparam int COLUMNS_DEF = 4096;
    localparam int VAL_W       = 16;
    localparam int COL_W       = 12;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int SUM_W       = 44;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [VAL_W-1:0] mat_value;
        logic [VAL_W-1:0] vec_value;
        logic [COL_W-1:0] col_index;
        logic             first_row;
        logic             last_row;
    } vmp_in_t;

    typedef struct packed {
        logic [COL_W-1:0] out_column;
        logic [SUM_W-1:0] dot_value;
    } vmp_out_t;

    // status of the write-back stage
    typedef struct packed {
        logic valid;
        logic last;
    } vmp_stat_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] base,
                                                  input logic [PROD_W-1:0] prod);
        logic [SUM_W:0] s;
        s = {1'b0, base} + (SUM_W + 1)'(prod);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// File: sv/vmp_ram.sv
// Column accumulator store: one write port, one read port, registered read.
// Depends on: vmp_pkg.
module vmp_ram #(
    parameter int DEPTH  = vmp_pkg::COLUMNS_DEF,
    parameter int ADDR_W = $clog2(vmp_pkg::COLUMNS_DEF)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [vmp_pkg::SUM_W-1:0] rd_data,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [vmp_pkg::SUM_W-1:0] wr_data
);
    import vmp_pkg::*;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/vmp_acc.sv
// Multiply / accumulate pipeline: product stage, then add and write-back stage,
// with forwarding of recent writes around the store's read latency.
// Depends on: vmp_pkg.
module vmp_acc #(
    parameter int ADDR_W = $clog2(vmp_pkg::COLUMNS_DEF)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      take,
    input  vmp_pkg::vmp_in_t          item,
    input  logic [ADDR_W-1:0]         addr,
    input  logic [vmp_pkg::SUM_W-1:0] rd_data,
    output logic                      wr_en,
    output logic [ADDR_W-1:0]         wr_addr,
    output logic [vmp_pkg::SUM_W-1:0] wr_data,
    output vmp_pkg::vmp_stat_t        stat,
    output vmp_pkg::vmp_out_t         res
);
    import vmp_pkg::*;

    // product stage
    logic              s1_valid_reg;
    vmp_in_t           s1_item_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // add / write-back stage
    logic              s2_valid_reg;
    logic              s2_first_reg;
    logic              s2_last_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [SUM_W-1:0]  s2_base_reg;

    // most recent write, missed by a read on the same edge
    logic              wl_valid_reg;
    logic [ADDR_W-1:0] wl_addr_reg;
    logic [SUM_W-1:0]  wl_data_reg;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  base_next;

    assign prod = PROD_W'(s1_item_reg.mat_value) * PROD_W'(s1_item_reg.vec_value);

    always_comb
    begin
        if (s2_first_reg)
        begin
            sum = SUM_W'(s2_prod_reg);
        end
        else
        begin
            sum = sat_add(s2_base_reg, s2_prod_reg);
        end
    end

    always_comb
    begin
        priority if (s2_valid_reg && (s2_addr_reg == s1_addr_reg))
        begin
            base_next = sum;
        end
        else if (wl_valid_reg && (wl_addr_reg == s1_addr_reg))
        begin
            base_next = wl_data_reg;
        end
        else
        begin
            base_next = rd_data;
        end
    end

    assign wr_en   = en && s2_valid_reg;
    assign wr_addr = s2_addr_reg;
    assign wr_data = sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wl_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                s1_valid_reg <= take;
                s2_valid_reg <= s1_valid_reg;
            end
            if (wr_en)
            begin
                wl_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (take)
            begin
                s1_item_reg <= item;
                s1_addr_reg <= addr;
            end
            s2_first_reg <= s1_item_reg.first_row;
            s2_last_reg  <= s1_item_reg.last_row;
            s2_col_reg   <= s1_item_reg.col_index;
            s2_addr_reg  <= s1_addr_reg;
            s2_prod_reg  <= prod;
            s2_base_reg  <= base_next;
        end
        if (wr_en)
        begin
            wl_addr_reg <= s2_addr_reg;
            wl_data_reg <= sum;
        end
    end

    assign stat.valid     = s2_valid_reg;
    assign stat.last      = s2_last_reg;
    assign res.out_column = s2_col_reg;
    assign res.dot_value  = sum;

endmodule

// File: sv/vector_matrix_product.sv
// Channel  Handshake                    Payload
// item     item_valid / item_ready      item   (vmp_in_t: element, coefficient, column, flags)
// result   result_valid / result_ready  result (vmp_out_t: column, finished sum)
//
// One word accepted per cycle while item_ready is high. A last-row word's sum passes through
// store read and multiply, add and write-back, then the output register.
// Accumulators live in one memory with registered read; the two writes still in flight
// are forwarded. The store is not cleared: reset clears only pipeline valid bits.
// item_ready drops only while a finished sum waits behind an unread result word.
// Words with col_index >= COLUMNS are accepted and dropped.
// Depends on: vmp_pkg, vmp_ram, vmp_acc, vector_matrix_product_assert.svh.
`include "vector_matrix_product_assert.svh"

module vector_matrix_product #(
    parameter int COLUMNS = vmp_pkg::COLUMNS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  vmp_pkg::vmp_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output vmp_pkg::vmp_out_t result
);
    import vmp_pkg::*;

    localparam int ADDR_W = $clog2(COLUMNS);
    localparam int EXT_W  = ADDR_W + COL_W;

    logic              en;
    logic              accept;
    logic              in_range;
    logic              take;
    logic [EXT_W-1:0]  col_ext;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SUM_W-1:0]  wr_data;
    vmp_stat_t         stat;
    vmp_out_t          res;
    logic              load;
    logic              result_valid_reg;
    logic              result_valid_next;
    vmp_out_t          result_reg;

    assign col_ext  = EXT_W'(item.col_index);
    assign addr     = col_ext[ADDR_W-1:0];
    assign in_range = 32'(item.col_index) < COLUMNS;

    // stall only when a finished sum cannot move into the output register
    assign en         = !(stat.valid && stat.last && result_valid_reg && !result_ready);
    assign item_ready = en;
    assign accept     = item_valid && en;
    assign take       = accept && in_range;
    assign load       = en && stat.valid && stat.last;

    vmp_ram #(
        .DEPTH  (COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    vmp_acc #(
        .ADDR_W (ADDR_W)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .take    (take),
        .item    (item),
        .addr    (addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .stat    (stat),
        .res     (res)
    );

    always_comb
    begin
        priority if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `VMP_ASSERT_NOW(a_ready_when_out_empty, !result_valid, item_ready, "item_ready low with empty output")
    `VMP_ASSERT_NOW(a_no_write_in_stall, !item_ready, !wr_en, "store written during stall")
    `VMP_ASSERT_NEXT(a_sum_reaches_output, en && stat.valid && stat.last, result_valid, "finished sum lost")

endmodule
